>>> hw/rtl/plist_pkg.sv
package plist_pkg;

    // List geometry
    localparam int CAPACITY     = 64;
    localparam int ELEMENT_BITS = 32;
    localparam int ADDR_W       = $clog2(CAPACITY);
    localparam int CNT_W        = $clog2(CAPACITY + 1);

    // Stream field widths
    localparam int ACTION_W   = 3;
    localparam int POS_W      = 7;
    localparam int DATA_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int FPOS_W     = 6;
    localparam int COUNT_W    = 7;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    typedef logic [ELEMENT_BITS-1:0] elem_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [ADDR_W-1:0]       addr_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_READ      = 3'd0,
        ACT_OVERWRITE = 3'd1,
        ACT_INSERT    = 3'd2,
        ACT_APPEND    = 3'd3,
        ACT_REMOVE    = 3'd4,
        ACT_SEARCH    = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_RANGE     = 2'd1,
        STS_FULL      = 2'd2,
        STS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_REMOVE,
        ST_INSERT,
        ST_PLACE,
        ST_SEARCH,
        ST_RESULT
    } state_t;

    // Keep the low element bits of a signed input value
    function automatic elem_t to_elem(logic [DATA_W-1:0] v);
        to_elem = elem_t'(signed'(v));
    endfunction

    // Sign-extend (or trim) a stored element to the output field
    function automatic logic [DATA_W-1:0] to_data(elem_t e);
        to_data = DATA_W'(signed'(e));
    endfunction

endpackage

>>> hw/rtl/positional_list_engine_top.sv
// Positional list engine: a bounded list of up to 64 signed elements held in a
// single-port-write, single-port-read synchronous RAM. Each request item on the
// slave stream reads, overwrites, inserts, appends, removes or searches, and
// yields exactly one result item on the master stream carrying the status, the
// returned element, the found position, the element count after the operation
// and an empty flag. Requests are worked one at a time and tready is high only
// while the engine is idle; a finished result sits in the output register, so
// the next request is taken while that result waits. Append, insert at the
// end, a rejected request and an unused action go straight to the result;
// read, overwrite and remove first fetch the element, and remove then moves
// any later entries down; insert inside the list moves the entries from the
// top down to the position up and then places the value; search scans from
// position 0 to a match or the end of the list. The shift and scan loops move
// one RAM entry per cycle, so the RAM port sets the worst case.
// Entries of the RAM are never cleared; only positions below the count are read.
module positional_list_engine_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // Request stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata, from bit 0: position[6:0], value[38:7], zero pad[39]
    input  logic [plist_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser, from bit 0: action[2:0]
    input  logic [plist_pkg::ACTION_W-1:0]     s_axis_tuser,
    // Result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata, from bit 0: data_out[31:0], found_position[37:32],
    // list_count[44:38], list_empty[45], zero pad[47:46]
    output logic [plist_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // tuser, from bit 0: status[1:0]
    output logic [plist_pkg::STATUS_W-1:0]     m_axis_tuser
);

    // Control state
    plist_pkg::state_t  state_reg, state_next;
    plist_pkg::cnt_t    count_reg, count_next;
    plist_pkg::cnt_t    idx_reg, idx_next;
    logic               m_valid_reg, m_valid_next;

    // Request and pending result payload
    plist_pkg::action_t act_reg, act_next;
    plist_pkg::cnt_t    pos_reg, pos_next;
    plist_pkg::elem_t   val_reg, val_next;
    plist_pkg::status_t res_status_reg, res_status_next;
    logic [plist_pkg::DATA_W-1:0] res_data_reg, res_data_next;
    logic [plist_pkg::FPOS_W-1:0] res_fpos_reg, res_fpos_next;

    // Output register payload
    plist_pkg::status_t out_status_reg, out_status_next;
    logic [plist_pkg::DATA_W-1:0]  out_data_reg, out_data_next;
    logic [plist_pkg::FPOS_W-1:0]  out_fpos_reg, out_fpos_next;
    logic [plist_pkg::COUNT_W-1:0] out_count_reg, out_count_next;
    logic                          out_empty_reg, out_empty_next;

    // Element RAM port
    logic               ram_we;
    plist_pkg::addr_t   ram_waddr;
    plist_pkg::elem_t   ram_wdata;
    plist_pkg::addr_t   ram_raddr;
    plist_pkg::elem_t   ram_rdata;

    // Request fields
    plist_pkg::action_t in_act;
    plist_pkg::cnt_t    in_pos;
    plist_pkg::elem_t   in_val;

    assign in_act = plist_pkg::action_t'(s_axis_tuser);
    assign in_pos = plist_pkg::cnt_t'(s_axis_tdata[plist_pkg::POS_W-1:0]);
    assign in_val = plist_pkg::to_elem(
        s_axis_tdata[plist_pkg::POS_W+plist_pkg::DATA_W-1:plist_pkg::POS_W]);

    plist_ram #(
        .DEPTH (plist_pkg::CAPACITY),
        .WIDTH (plist_pkg::ELEMENT_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= plist_pkg::ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_fpos_reg   <= res_fpos_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_fpos_reg   <= out_fpos_next;
        out_count_reg  <= out_count_next;
        out_empty_reg  <= out_empty_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        act_next        = act_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_fpos_next   = res_fpos_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_fpos_next   = out_fpos_reg;
        out_count_next  = out_count_reg;
        out_empty_next  = out_empty_reg;
        // drop the output item once the sink takes it
        m_valid_next    = m_valid_reg & ~m_axis_tready;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg[plist_pkg::ADDR_W-1:0];
        ram_wdata       = ram_rdata;
        ram_raddr       = '0;
        s_axis_tready   = (state_reg == plist_pkg::ST_IDLE);

        unique case (state_reg)
            plist_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    act_next        = in_act;
                    pos_next        = in_pos;
                    val_next        = in_val;
                    res_status_next = plist_pkg::STS_OK;
                    res_data_next   = '0;
                    res_fpos_next   = '0;
                    state_next      = plist_pkg::ST_RESULT;
                    unique case (in_act) inside
                        plist_pkg::ACT_READ, plist_pkg::ACT_OVERWRITE,
                        plist_pkg::ACT_REMOVE:
                        begin
                            if (in_pos >= count_reg)
                            begin
                                res_status_next = plist_pkg::STS_RANGE;
                            end
                            else
                            begin
                                ram_raddr  = in_pos[plist_pkg::ADDR_W-1:0];
                                state_next = plist_pkg::ST_FETCH;
                            end
                        end
                        plist_pkg::ACT_INSERT:
                        begin
                            if (in_pos > count_reg)
                            begin
                                res_status_next = plist_pkg::STS_RANGE;
                            end
                            else if (count_reg == plist_pkg::cnt_t'(plist_pkg::CAPACITY))
                            begin
                                res_status_next = plist_pkg::STS_FULL;
                            end
                            else if (in_pos == count_reg)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = in_pos[plist_pkg::ADDR_W-1:0];
                                ram_wdata  = in_val;
                                count_next = plist_pkg::cnt_t'(count_reg + 1'b1);
                            end
                            else
                            begin
                                // shift up from the top entry
                                ram_raddr  = plist_pkg::addr_t'(count_reg - 1'b1);
                                idx_next   = count_reg;
                                state_next = plist_pkg::ST_INSERT;
                            end
                        end
                        plist_pkg::ACT_APPEND:
                        begin
                            if (count_reg == plist_pkg::cnt_t'(plist_pkg::CAPACITY))
                            begin
                                res_status_next = plist_pkg::STS_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[plist_pkg::ADDR_W-1:0];
                                ram_wdata  = in_val;
                                count_next = plist_pkg::cnt_t'(count_reg + 1'b1);
                            end
                        end
                        plist_pkg::ACT_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = plist_pkg::STS_NOT_FOUND;
                            end
                            else
                            begin
                                ram_raddr  = '0;
                                idx_next   = '0;
                                state_next = plist_pkg::ST_SEARCH;
                            end
                        end
                        default:
                        begin
                            // unused actions: report ok, change nothing
                        end
                    endcase
                end
            end

            plist_pkg::ST_FETCH:
            begin
                res_data_next = plist_pkg::to_data(ram_rdata);
                state_next    = plist_pkg::ST_RESULT;
                unique case (act_reg) inside
                    plist_pkg::ACT_OVERWRITE:
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = pos_reg[plist_pkg::ADDR_W-1:0];
                        ram_wdata = val_reg;
                    end
                    plist_pkg::ACT_REMOVE:
                    begin
                        if (plist_pkg::cnt_t'(pos_reg + 1'b1) < count_reg)
                        begin
                            ram_raddr  = plist_pkg::addr_t'(pos_reg + 1'b1);
                            idx_next   = pos_reg;
                            state_next = plist_pkg::ST_REMOVE;
                        end
                        else
                        begin
                            count_next = plist_pkg::cnt_t'(count_reg - 1'b1);
                        end
                    end
                    default:
                    begin
                        // plain read: the old element is the result
                    end
                endcase
            end

            plist_pkg::ST_REMOVE:
            begin
                // move entry idx+1 down to idx, fetching the next one ahead
                ram_we = 1'b1;
                if (plist_pkg::cnt_t'(idx_reg + 2'd2) < count_reg)
                begin
                    ram_raddr = plist_pkg::addr_t'(idx_reg + 2'd2);
                    idx_next  = plist_pkg::cnt_t'(idx_reg + 1'b1);
                end
                else
                begin
                    count_next = plist_pkg::cnt_t'(count_reg - 1'b1);
                    state_next = plist_pkg::ST_RESULT;
                end
            end

            plist_pkg::ST_INSERT:
            begin
                // move entry idx-1 up to idx, fetching the one below ahead
                ram_we = 1'b1;
                if (plist_pkg::cnt_t'(idx_reg - 1'b1) > pos_reg)
                begin
                    ram_raddr = plist_pkg::addr_t'(idx_reg - 2'd2);
                    idx_next  = plist_pkg::cnt_t'(idx_reg - 1'b1);
                end
                else
                begin
                    state_next = plist_pkg::ST_PLACE;
                end
            end

            plist_pkg::ST_PLACE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[plist_pkg::ADDR_W-1:0];
                ram_wdata  = val_reg;
                count_next = plist_pkg::cnt_t'(count_reg + 1'b1);
                state_next = plist_pkg::ST_RESULT;
            end

            plist_pkg::ST_SEARCH:
            begin
                if (ram_rdata == val_reg)
                begin
                    res_status_next = plist_pkg::STS_OK;
                    res_fpos_next   = idx_reg[plist_pkg::FPOS_W-1:0];
                    state_next      = plist_pkg::ST_RESULT;
                end
                else if (plist_pkg::cnt_t'(idx_reg + 1'b1) < count_reg)
                begin
                    ram_raddr = plist_pkg::addr_t'(idx_reg + 1'b1);
                    idx_next  = plist_pkg::cnt_t'(idx_reg + 1'b1);
                end
                else
                begin
                    res_status_next = plist_pkg::STS_NOT_FOUND;
                    state_next      = plist_pkg::ST_RESULT;
                end
            end

            plist_pkg::ST_RESULT:
            begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_status_next = res_status_reg;
                    out_data_next   = res_data_reg;
                    out_fpos_next   = res_fpos_reg;
                    out_count_next  = plist_pkg::COUNT_W'(count_reg);
                    out_empty_next  = (count_reg == '0);
                    m_valid_next    = 1'b1;
                    state_next      = plist_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = plist_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {2'b00, out_empty_reg, out_count_reg, out_fpos_reg, out_data_reg};

endmodule

>>> hw/rtl/plist_ram.sv
module plist_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Action codes beyond the defined set: the block must leave the list alone
    localparam logic [plist_pkg::ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [plist_pkg::ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

    localparam int RESET_CYCLES     = 11;
    localparam int RANDOM_PER_PHASE = 375;
    // Allow a good margin after the last result
    localparam int TAIL_CYCLES      = 100;
    localparam int CYCLE_LIMIT      = 1_000_000;

    // Idle plans per phase: none, sender only, receiver only, both
    localparam int SEND_IDLE_PLAN [4] = '{0, 53, 0, 19};
    localparam int RECV_STALL_PLAN[4] = '{0, 0, 53, 19};

    // One result item, unpacked from the result stream
    typedef struct packed {
        logic [plist_pkg::STATUS_W-1:0] status;
        logic [plist_pkg::DATA_W-1:0]   data;
        logic [plist_pkg::FPOS_W-1:0]   fpos;
        logic [plist_pkg::COUNT_W-1:0]  count;
        logic                           empty;
    } list_result_t;

    // One row of the directed table; want is used only where typed is set
    typedef struct packed {
        logic [plist_pkg::ACTION_W-1:0] act;
        logic [plist_pkg::POS_W-1:0]    pos;
        logic [plist_pkg::DATA_W-1:0]   val;
        logic                           fill;   // top the list up to capacity before this row
        logic                           typed;  // expectation written in the row
        list_result_t                   want;
    } directed_row_t;

    localparam list_result_t NO_RESULT = '0;

    localparam int DIRECTED_ROWS_N = 26;
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_ROWS_N] = '{
        // empty list straight after reset: everything positional is out of range
        '{plist_pkg::ACT_READ,      7'd0,   32'h0000_0000, 1'b0, 1'b1,
          '{plist_pkg::STS_RANGE,     32'h0, 6'd0, 7'd0,  1'b1}},
        '{plist_pkg::ACT_REMOVE,    7'd0,   32'h0000_0000, 1'b0, 1'b1,
          '{plist_pkg::STS_RANGE,     32'h0, 6'd0, 7'd0,  1'b1}},
        '{plist_pkg::ACT_SEARCH,    7'd0,   32'h0000_0000, 1'b0, 1'b1,
          '{plist_pkg::STS_NOT_FOUND, 32'h0, 6'd0, 7'd0,  1'b1}},
        '{plist_pkg::ACT_INSERT,    7'd1,   32'h0000_0005, 1'b0, 1'b1,
          '{plist_pkg::STS_RANGE,     32'h0, 6'd0, 7'd0,  1'b1}},
        '{plist_pkg::ACT_OVERWRITE, 7'd0,   32'h0000_0009, 1'b0, 1'b1,
          '{plist_pkg::STS_RANGE,     32'h0, 6'd0, 7'd0,  1'b1}},
        // extremes of the value field
        '{plist_pkg::ACT_APPEND,    7'd127, 32'h7FFF_FFFF, 1'b0, 1'b1,
          '{plist_pkg::STS_OK,        32'h0, 6'd0, 7'd1,  1'b0}},
        '{plist_pkg::ACT_APPEND,    7'd0,   32'h8000_0000, 1'b0, 1'b1,
          '{plist_pkg::STS_OK,        32'h0, 6'd0, 7'd2,  1'b0}},
        '{plist_pkg::ACT_INSERT,    7'd0,   32'hFFFF_FFFF, 1'b0, 1'b0, NO_RESULT},
        // insert at the count appends
        '{plist_pkg::ACT_INSERT,    7'd3,   32'h0000_0000, 1'b0, 1'b0, NO_RESULT},
        '{plist_pkg::ACT_READ,      7'd1,   32'h0000_0000, 1'b0, 1'b0, NO_RESULT},
        '{plist_pkg::ACT_OVERWRITE, 7'd3,   32'h5A5A_5A5A, 1'b0, 1'b0, NO_RESULT},
        '{plist_pkg::ACT_SEARCH,    7'd0,   32'h8000_0000, 1'b0, 1'b0, NO_RESULT},
        '{plist_pkg::ACT_SEARCH,    7'd0,   32'h1234_5678, 1'b0, 1'b0, NO_RESULT},
        // positions past the end
        '{plist_pkg::ACT_READ,      7'd127, 32'h0000_0000, 1'b0, 1'b1,
          '{plist_pkg::STS_RANGE,     32'h0, 6'd0, 7'd4,  1'b0}},
        '{plist_pkg::ACT_REMOVE,    7'd4,   32'h0000_0000, 1'b0, 1'b1,
          '{plist_pkg::STS_RANGE,     32'h0, 6'd0, 7'd4,  1'b0}},
        '{plist_pkg::ACT_INSERT,    7'd5,   32'h0000_0001, 1'b0, 1'b1,
          '{plist_pkg::STS_RANGE,     32'h0, 6'd0, 7'd4,  1'b0}},
        // unused actions change nothing
        '{ACT_SPARE_6,              7'd0,   32'hFFFF_FFFF, 1'b0, 1'b1,
          '{plist_pkg::STS_OK,        32'h0, 6'd0, 7'd4,  1'b0}},
        '{ACT_SPARE_7,              7'd127, 32'hFFFF_FFFF, 1'b0, 1'b1,
          '{plist_pkg::STS_OK,        32'h0, 6'd0, 7'd4,  1'b0}},
        '{plist_pkg::ACT_REMOVE,    7'd0,   32'h0000_0000, 1'b0, 1'b0, NO_RESULT},
        // full list: appends and in-range inserts are refused
        '{plist_pkg::ACT_APPEND,    7'd0,   32'h0000_0001, 1'b1, 1'b1,
          '{plist_pkg::STS_FULL,      32'h0, 6'd0, 7'd64, 1'b0}},
        '{plist_pkg::ACT_INSERT,    7'd64,  32'h0000_0002, 1'b0, 1'b1,
          '{plist_pkg::STS_FULL,      32'h0, 6'd0, 7'd64, 1'b0}},
        // range is reported ahead of full
        '{plist_pkg::ACT_INSERT,    7'd65,  32'h0000_0003, 1'b0, 1'b1,
          '{plist_pkg::STS_RANGE,     32'h0, 6'd0, 7'd64, 1'b0}},
        '{plist_pkg::ACT_INSERT,    7'd0,   32'h0000_0004, 1'b0, 1'b1,
          '{plist_pkg::STS_FULL,      32'h0, 6'd0, 7'd64, 1'b0}},
        '{plist_pkg::ACT_SEARCH,    7'd0,   32'h7FFF_FFFF, 1'b0, 1'b0, NO_RESULT},
        '{plist_pkg::ACT_REMOVE,    7'd63,  32'h0000_0000, 1'b0, 1'b0, NO_RESULT},
        '{plist_pkg::ACT_REMOVE,    7'd0,   32'h0000_0000, 1'b0, 1'b0, NO_RESULT}
    };

    typedef enum int {EP_GROW, EP_SHRINK, EP_MIXED, EP_NOISE} episode_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [plist_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [plist_pkg::ACTION_W-1:0]    s_axis_tuser = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [plist_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [plist_pkg::STATUS_W-1:0]    m_axis_tuser;

    // Shadow copy of the list, advanced as each request item is accepted
    plist_pkg::elem_t list_mem [plist_pkg::CAPACITY];
    int               list_len = 0;
    list_result_t     pending_results[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int cycle_count    = 0;

    // Run statistics for the closing summary
    int action_seen [8];
    int status_seen [4];
    int results_checked = 0;
    int peak_len        = 0;
    int times_emptied   = 0;

    positional_list_engine_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 clk = ~clk;

    // Work out the result of one request and advance the shadow list.
    // Elements are as wide as the data field, so values pass through unchanged.
    function automatic list_result_t apply_request(
        logic [plist_pkg::ACTION_W-1:0] act,
        logic [plist_pkg::POS_W-1:0]    pos,
        logic [plist_pkg::DATA_W-1:0]   val);
        list_result_t res;
        int           slot;
        int           k;
        res  = '0;
        slot = int'(pos);
        case (act) inside
            plist_pkg::ACT_READ, plist_pkg::ACT_OVERWRITE, plist_pkg::ACT_REMOVE:
            begin
                if (slot >= list_len)
                    res.status = plist_pkg::STS_RANGE;
                else
                begin
                    res.data = list_mem[slot];
                    if (act == plist_pkg::ACT_OVERWRITE)
                        list_mem[slot] = val;
                    else if (act == plist_pkg::ACT_REMOVE)
                    begin
                        // close the gap: later entries move down one place
                        for (k = slot; k < list_len - 1; k++)
                            list_mem[k] = list_mem[k + 1];
                        list_len--;
                        if (list_len == 0)
                            times_emptied++;
                    end
                end
            end
            plist_pkg::ACT_INSERT, plist_pkg::ACT_APPEND:
            begin
                if (act == plist_pkg::ACT_APPEND)
                    slot = list_len;
                if (slot > list_len)
                    res.status = plist_pkg::STS_RANGE;
                else if (list_len >= plist_pkg::CAPACITY)
                    res.status = plist_pkg::STS_FULL;
                else
                begin
                    // open a gap: entries at and after the slot move up one place
                    for (k = list_len; k > slot; k--)
                        list_mem[k] = list_mem[k - 1];
                    list_mem[slot] = val;
                    list_len++;
                end
            end
            plist_pkg::ACT_SEARCH:
            begin
                res.status = plist_pkg::STS_NOT_FOUND;
                for (k = 0; k < list_len; k++)
                begin
                    if (list_mem[k] == val)
                    begin
                        res.status = plist_pkg::STS_OK;
                        res.fpos   = plist_pkg::FPOS_W'(k);
                        break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.count = plist_pkg::COUNT_W'(list_len);
        res.empty = (list_len == 0);
        if (list_len > peak_len)
            peak_len = list_len;
        return res;
    endfunction

    // Offer one request item, hold it until taken, then queue what it should yield
    task automatic push_request(input logic [plist_pkg::ACTION_W-1:0] act,
                                input logic [plist_pkg::POS_W-1:0] pos,
                                input logic [plist_pkg::DATA_W-1:0] val,
                                input logic typed,
                                input list_result_t typed_res);
        list_result_t res;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, val, pos};
        s_axis_tuser  <= act;
        do
            @(posedge clk);
        while (!s_axis_tready);
        res = apply_request(act, pos, val);
        if (typed)
            res = typed_res;
        pending_results.push_back(res);
        action_seen[act]++;
    endtask

    // Drop valid and hold off until every queued result has come back
    task automatic await_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Build one random request shaped by the current episode.
    // counted is cleared for unused actions, which the block simply ignores.
    task automatic random_request(input episode_t mode, output logic counted);
        int                             roll;
        logic [plist_pkg::ACTION_W-1:0] act;
        logic [plist_pkg::POS_W-1:0]    pos;
        logic [plist_pkg::DATA_W-1:0]   val;
        roll = $urandom_range(99);
        case (mode)
            EP_GROW:
                act = roll < 50 ? plist_pkg::ACT_APPEND :
                      roll < 85 ? plist_pkg::ACT_INSERT :
                      roll < 93 ? plist_pkg::ACT_SEARCH : plist_pkg::ACT_READ;
            EP_SHRINK:
                act = roll < 60 ? plist_pkg::ACT_REMOVE :
                      roll < 75 ? plist_pkg::ACT_READ :
                      roll < 90 ? plist_pkg::ACT_SEARCH : plist_pkg::ACT_OVERWRITE;
            EP_MIXED:
                act = plist_pkg::ACTION_W'($urandom_range(plist_pkg::ACT_SEARCH));
            default:
                act = plist_pkg::ACTION_W'($urandom_range(7));
        endcase

        // mostly legal positions, then just past the end, then far out
        roll = $urandom_range(99);
        if (mode == EP_NOISE || roll >= 93)
            pos = plist_pkg::POS_W'($urandom_range(127));
        else if (roll < 75)
        begin
            if (act == plist_pkg::ACT_INSERT)
                pos = plist_pkg::POS_W'($urandom_range(list_len));
            else
                pos = list_len > 0 ? plist_pkg::POS_W'($urandom_range(list_len - 1)) : '0;
        end
        else if (roll < 85)
            pos = plist_pkg::POS_W'(list_len + $urandom_range(2));
        else
            pos = plist_pkg::POS_W'($urandom_range(127, 64));

        // extremes, copies of held values (so searches hit), or anything
        roll = $urandom_range(99);
        if (roll < 10)
        begin
            case ($urandom_range(3))
                0: val = 32'h8000_0000;
                1: val = 32'h7FFF_FFFF;
                2: val = 32'hFFFF_FFFF;
                default: val = 32'h0000_0000;
            endcase
        end
        else if (roll < 45 && list_len > 0)
            val = list_mem[$urandom_range(list_len - 1)];
        else
            val = $urandom();

        push_request(act, pos, val, 1'b0, NO_RESULT);
        counted = (act <= plist_pkg::ACT_SEARCH);
    endtask

    task automatic compare_field(input string name,
                                 input logic [plist_pkg::DATA_W-1:0] want,
                                 input logic [plist_pkg::DATA_W-1:0] got);
        if (want !== got)
        begin
            fail_count++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    // Result side: check each accepted result item, then choose the next stall
    always @(posedge clk)
    begin : result_monitor
        list_result_t got;
        list_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status = m_axis_tuser;
            got.data   = m_axis_tdata[31:0];
            got.fpos   = m_axis_tdata[37:32];
            got.count  = m_axis_tdata[44:38];
            got.empty  = m_axis_tdata[45];
            if (pending_results.size() == 0)
            begin
                fail_count++;
                $error("result item with nothing outstanding: tdata 0x%0h status %0d",
                       m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("status", plist_pkg::DATA_W'(want.status),
                              plist_pkg::DATA_W'(got.status));
                compare_field("data_out", want.data, got.data);
                compare_field("found_position", plist_pkg::DATA_W'(want.fpos),
                              plist_pkg::DATA_W'(got.fpos));
                compare_field("list_count", plist_pkg::DATA_W'(want.count),
                              plist_pkg::DATA_W'(got.count));
                compare_field("list_empty", plist_pkg::DATA_W'(want.empty),
                              plist_pkg::DATA_W'(got.empty));
                status_seen[got.status]++;
                results_checked++;
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: give up if the run never drains
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("positional_list_engine_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        int            phase;
        int            row;
        int            sent;
        int            run_len;
        int            k;
        int            roll;
        logic          counted;
        episode_t      mode;
        directed_row_t entry;

        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = SEND_IDLE_PLAN[phase];
            recv_stall_pct = RECV_STALL_PLAN[phase];

            // Directed table first, with no idling on either side
            if (phase == 0)
            begin
                for (row = 0; row < DIRECTED_ROWS_N; row++)
                begin
                    entry = DIRECTED_ROWS[row];
                    if (entry.fill)
                    begin
                        while (list_len < plist_pkg::CAPACITY)
                            push_request(plist_pkg::ACT_APPEND,
                                         plist_pkg::POS_W'($urandom_range(127)),
                                         $urandom(), 1'b0, NO_RESULT);
                    end
                    push_request(entry.act, entry.pos, entry.val, entry.typed, entry.want);
                end
            end

            // Random episodes: runs of growth, shrinkage, mixed traffic and noise
            sent = 0;
            while (sent < RANDOM_PER_PHASE)
            begin
                roll = $urandom_range(99);
                mode = roll < 35 ? EP_GROW : roll < 65 ? EP_SHRINK :
                       roll < 90 ? EP_MIXED : EP_NOISE;
                run_len = (mode == EP_GROW || mode == EP_SHRINK) ?
                          $urandom_range(100, 40) : $urandom_range(40, 10);
                for (k = 0; k < run_len && sent < RANDOM_PER_PHASE; k++)
                begin
                    random_request(mode, counted);
                    if (counted)
                        sent++;
                end
            end

            // Let the block run dry before the idle plan changes
            await_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Requests: read %0d, overwrite %0d, insert %0d, append %0d, remove %0d, "
                 , action_seen[plist_pkg::ACT_READ], action_seen[plist_pkg::ACT_OVERWRITE],
                 action_seen[plist_pkg::ACT_INSERT], action_seen[plist_pkg::ACT_APPEND],
                 action_seen[plist_pkg::ACT_REMOVE],
                 "search %0d, unused %0d; %0d results checked",
                 action_seen[plist_pkg::ACT_SEARCH],
                 action_seen[ACT_SPARE_6] + action_seen[ACT_SPARE_7],
                 results_checked);
        $display("Outcomes: ok %0d, out of range %0d, full %0d, search miss %0d; "
                 , status_seen[plist_pkg::STS_OK], status_seen[plist_pkg::STS_RANGE],
                 status_seen[plist_pkg::STS_FULL], status_seen[plist_pkg::STS_NOT_FOUND],
                 "list peaked at %0d entries and ran empty %0d times",
                 peak_len, times_emptied);

        if (fail_count == 0)
            $display("positional_list_engine_top regression: pass");
        else
            $display("positional_list_engine_top regression: fail");
        $finish;
    end

endmodule
